// ===== hdl/lnr_pkg.sv =====
// lnr_pkg: shared constants for the layer normalisation row block
// no dependencies
`default_nettype none
package lnr_pkg;
  // default buffer depth in elements
  localparam int ROW_MAX_DEF = 64;
  // reset value of the epsilon register, q16.16
  localparam logic [31:0] EPSILON_RESET = 32'd1;
  // state codes of the sequencer
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_COLLECT = 4'd0;
  localparam logic [ST_W-1:0] ST_NUM1 = 4'd1;
  localparam logic [ST_W-1:0] ST_NUM2 = 4'd2;
  localparam logic [ST_W-1:0] ST_DIV = 4'd3;
  localparam logic [ST_W-1:0] ST_POST_MEAN = 4'd4;
  localparam logic [ST_W-1:0] ST_POST_VAR = 4'd5;
  localparam logic [ST_W-1:0] ST_POST_RECIP = 4'd6;
  localparam logic [ST_W-1:0] ST_SQRT = 4'd7;
  localparam logic [ST_W-1:0] ST_RD = 4'd8;
  localparam logic [ST_W-1:0] ST_M1 = 4'd9;
  localparam logic [ST_W-1:0] ST_M2 = 4'd10;
  localparam logic [ST_W-1:0] ST_M3 = 4'd11;
  localparam logic [ST_W-1:0] ST_OUT = 4'd12;
  // which division the shared divider is running
  localparam logic [1:0] PH_MEAN = 2'd0;
  localparam logic [1:0] PH_VAR = 2'd1;
  localparam logic [1:0] PH_RECIP = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/layer_norm_row.sv =====
// layer_norm_row: fixed point layer normalisation over one buffered row
// depends on lnr_pkg (constants, state codes)
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   sample, scale, shift, row_end
// out      output     out_valid / out_ready norm_value, last_of_row, clipped, row_truncated
// cfg      input      cfg_valid / cfg_ready cfg_data (epsilon, q16.16)
//
// each element item is taken in one cycle while the row is collected.
// at row end the shared 64 step restoring divider finds the mean and, when needed, the
// variance and 2^64/d; the square root takes 32 steps when d > 1. each result then is
// read, scaled and held in ST_OUT through output stalls. in is not ready meanwhile.
// rst is synchronous and clears the sums, counts and sequencer; the element
// stores are not cleared. cfg is always ready.
`default_nettype none
module layer_norm_row #(
  parameter int ROW_MAX = lnr_pkg::ROW_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] scale,
  input  wire logic signed [15:0] shift,
  input  wire logic               row_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      norm_value,
  output logic                    last_of_row,
  output logic                    clipped,
  output logic                    row_truncated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data
);
  import lnr_pkg::*;

  localparam int CNT_W = $clog2(ROW_MAX + 1);
  localparam int IDX_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

  logic [ST_W-1:0] state;
  logic [1:0] phase;
  logic [31:0] epsilon;

  // row state
  logic signed [22:0] sum;
  logic [37:0] sumsq;
  logic [CNT_W-1:0] count;
  logic ovf;

  // element stores
  logic signed [15:0] sample_mem [ROW_MAX];
  logic signed [15:0] scale_mem [ROW_MAX];
  logic signed [15:0] shift_mem [ROW_MAX];
  logic signed [15:0] rd_sample, rd_scale, rd_shift;
  logic [IDX_W-1:0] k;

  // row statistics
  logic [44:0] nsq;
  logic signed [45:0] num;
  logic mean_neg;
  logic signed [24:0] mean;
  logic [32:0] rsq;

  // shared divider
  logic [63:0] dvd;
  logic [33:0] dvs;
  logic [33:0] rem;
  logic [5:0] div_cnt;
  logic [34:0] trial;
  logic div_ge;

  // square root
  logic [63:0] sq_v, sq_r, sq_bit, sq_trial, sq_r_next;
  logic sq_ge;

  // emission datapath
  logic signed [59:0] prod1;
  logic signed [51:0] prod2;

  logic in_acc;
  logic store_ok;
  logic signed [31:0] x_sq;
  logic signed [45:0] sum_sq;
  logic [32:0] a_raw, a_mag;
  logic [33:0] d_val;
  logic signed [25:0] cent;
  logic signed [33:0] rsq_s;
  logic signed [59:0] t_full;
  logic signed [35:0] t_val;
  logic signed [51:0] y_round;
  logic signed [36:0] y_val;
  logic last_k;

  assign in_ready = (state == ST_COLLECT);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;
  assign store_ok = (count < CNT_W'(ROW_MAX));
  assign last_k = ((CNT_W'(k) + CNT_W'(1)) == count);

  // combinational helpers
  always_comb begin
    x_sq = sample * sample;
    sum_sq = 46'(sum) * 46'(sum);
    a_raw = {sum[22], sum, 9'b0} + 33'(count);
    a_mag = a_raw[32] ? (~a_raw + 33'({count, 1'b0})) : a_raw;
    d_val = 34'(dvd[32:0]) + 34'(epsilon);
    trial = {rem, dvd[63]};
    div_ge = (trial >= {1'b0, dvs});
    sq_trial = sq_r + sq_bit;
    sq_ge = (sq_v >= sq_trial);
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
    cent = {{2{rd_sample[15]}}, rd_sample, 8'b0} - {mean[24], mean};
    rsq_s = $signed({1'b0, rsq});
    t_full = (prod1 + 60'sd8388608) >>> 24;
    t_val = t_full[35:0];
    y_round = (prod2 + 52'sd32768) >>> 16;
    y_val = 37'(y_round) + 37'(rd_shift);
  end

  // element stores, registered read at the emission index
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      sample_mem[count[IDX_W-1:0]] <= sample;
      scale_mem[count[IDX_W-1:0]] <= scale;
      shift_mem[count[IDX_W-1:0]] <= shift;
    end
    rd_sample <= sample_mem[k];
    rd_scale <= scale_mem[k];
    rd_shift <= shift_mem[k];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RESET;
    end else if (cfg_valid) begin
      epsilon <= cfg_data;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      phase <= PH_MEAN;
      sum <= '0;
      sumsq <= '0;
      count <= '0;
      ovf <= 1'b0;
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (in_acc) begin
            if (store_ok) begin
              sum <= sum + {{7{sample[15]}}, sample};
              sumsq <= sumsq + {6'b0, x_sq};
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (row_end) begin
              state <= ST_NUM1;
            end
          end
        end
        ST_NUM1: begin
          nsq <= {7'b0, sumsq} * 45'(count);
          state <= ST_NUM2;
        end
        ST_NUM2: begin
          num <= $signed({1'b0, nsq}) - sum_sq;
          mean_neg <= a_raw[32];
          dvd <= 64'(a_mag);
          dvs <= 34'({count, 1'b0});
          rem <= '0;
          div_cnt <= '0;
          phase <= PH_MEAN;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= div_ge ? 34'(trial - {1'b0, dvs}) : trial[33:0];
          dvd <= {dvd[62:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) begin
            case (phase)
              PH_MEAN: state <= ST_POST_MEAN;
              PH_VAR: state <= ST_POST_VAR;
              default: state <= ST_POST_RECIP;
            endcase
          end
        end
        ST_POST_MEAN: begin
          mean <= mean_neg ? (~dvd[24:0] + 25'd1) : dvd[24:0];
          rem <= '0;
          div_cnt <= '0;
          if (!num[45] && (num != '0)) begin
            dvd <= 64'(num);
            dvs <= 34'(count) * 34'(count);
            phase <= PH_VAR;
            state <= ST_DIV;
          end else begin
            dvd <= '0;
            state <= ST_POST_VAR;
          end
        end
        ST_POST_VAR: begin
          rem <= '0;
          div_cnt <= '0;
          if (d_val[33:1] == '0) begin
            rsq <= 33'h1_0000_0000;
            k <= '0;
            state <= ST_RD;
          end else begin
            dvd <= '1;
            dvs <= d_val;
            phase <= PH_RECIP;
            state <= ST_DIV;
          end
        end
        ST_POST_RECIP: begin
          sq_v <= dvd + 64'(rem == (dvs - 34'd1));
          sq_r <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_trial;
          end
          sq_r <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            rsq <= sq_r_next[32:0];
            k <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_M1;
        end
        ST_M1: begin
          prod1 <= cent * rsq_s;
          state <= ST_M2;
        end
        ST_M2: begin
          prod2 <= t_val * rd_scale;
          state <= ST_M3;
        end
        ST_M3: begin
          // saturate to q8.8
          if (y_val > 37'sd32767) begin
            norm_value <= 16'sh7fff;
            clipped <= 1'b1;
          end else if (y_val < -37'sd32768) begin
            norm_value <= -16'sh8000;
            clipped <= 1'b1;
          end else begin
            norm_value <= y_val[15:0];
            clipped <= 1'b0;
          end
          last_of_row <= last_k;
          row_truncated <= ovf;
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_k) begin
              sum <= '0;
              sumsq <= '0;
              count <= '0;
              ovf <= 1'b0;
              k <= '0;
              state <= ST_COLLECT;
            end else begin
              k <= k + IDX_W'(1);
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== verif/tb_layer_norm_row.sv =====
// tb_layer_norm_row: self-checking testbench for the layer normalisation row block
// depends on lnr_pkg and layer_norm_row; holds its own row predictor and scoreboard
`default_nettype none

// expected result of one buffered element
typedef struct {
  logic signed [15:0] value;
  bit                 last;
  bit                 clip;
  bit                 trunc;
} norm_result_t;

class norm_scoreboard;
  // row state mirrored from the block
  logic signed [15:0] samples[64];
  logic signed [15:0] gains[64];
  logic signed [15:0] biases[64];
  longint             row_sum;
  longint             row_sq_sum;
  int                 row_len;
  bit                 dropped;
  logic [31:0]        epsilon;
  norm_result_t       pending[$];
  int                 mismatches;

  function new();
    row_sum = 0;
    row_sq_sum = 0;
    row_len = 0;
    dropped = 0;
    epsilon = lnr_pkg::EPSILON_RESET;
    mismatches = 0;
  endfunction

  // floor division for a positive divisor
  function longint div_floor(longint a, longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  // round to nearest, halves up, then drop s fraction bits
  function longint round_drop(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // floor(2^32 / sqrt(d)) in q8.24
  function logic [63:0] inv_sqrt(logic [63:0] d);
    logic [64:0] q;
    logic [63:0] v, r, b;
    if (d <= 64'd1) return 64'h1_0000_0000;
    q = (65'd1 << 64) / {1'b0, d};
    v = q[63:0];
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // note one accepted element, and at row end work out its results
  function void note_input(logic signed [15:0] s, logic signed [15:0] g,
                           logic signed [15:0] h, bit re);
    longint n, mean, num, vr, c, t, y;
    logic [63:0] d, r;
    norm_result_t e;
    if (row_len < lnr_pkg::ROW_MAX_DEF) begin
      samples[row_len] = s;
      gains[row_len] = g;
      biases[row_len] = h;
      row_sum += longint'(s);
      row_sq_sum += longint'(s) * longint'(s);
      row_len++;
    end else begin
      dropped = 1;
    end
    if (!re) return;
    n = row_len;
    if (n == 0) begin
      dropped = 0;
      return;
    end
    mean = div_floor(row_sum * 512 + n, 2 * n);
    num = n * row_sq_sum - row_sum * row_sum;
    vr = (num > 0) ? num / (n * n) : 0;
    d = 64'(vr) + 64'(epsilon);
    r = inv_sqrt(d);
    for (int k = 0; k < row_len; k++) begin
      c = longint'(samples[k]) * 256 - mean;
      t = round_drop(c * longint'(r), 24);
      y = round_drop(t * longint'(gains[k]), 16) + longint'(biases[k]);
      e.clip = 0;
      if (y > 32767) begin
        y = 32767;
        e.clip = 1;
      end
      if (y < -32768) begin
        y = -32768;
        e.clip = 1;
      end
      e.value = 16'(y);
      e.last = (k + 1 == row_len);
      e.trunc = dropped;
      pending.push_back(e);
    end
    row_sum = 0;
    row_sq_sum = 0;
    row_len = 0;
    dropped = 0;
  endfunction

  // compare one accepted result with the oldest expectation
  function void check(logic signed [15:0] v, bit l, bit c, bit tr);
    norm_result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: value %0d last %0b clip %0b trunc %0b", v, l, c, tr);
      return;
    end
    e = pending.pop_front();
    if (e.value !== v || e.last !== l || e.clip !== c || e.trunc !== tr) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %0d last %0b clip %0b trunc %0b, got %0d %0b %0b %0b",
                 e.value, e.last, e.clip, e.trunc, v, l, c, tr);
    end
  endfunction
endclass

module tb_layer_norm_row;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1500000;
  // idle modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk, rst;
  logic in_valid, in_ready;
  logic signed [15:0] sample, scale, shift;
  logic row_end;
  logic out_valid, out_ready;
  logic signed [15:0] norm_value;
  logic last_of_row, clipped, row_truncated;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;

  norm_scoreboard sb;
  int idle_mode;
  int hold_req, hold_ack, hold_left;
  int cycles;
  int items_sent;

  layer_norm_row dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .scale(scale), .shift(shift), .row_end(row_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .norm_value(norm_value), .last_of_row(last_of_row),
    .clipped(clipped), .row_truncated(row_truncated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** layer_norm_row: FAILED **");
      $finish;
    end
  end

  // result side: check accepted items, drive ready with stalls and long hold-offs
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check(norm_value, last_of_row, clipped, row_truncated);
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready <= ($urandom_range(99) >= 45);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 11);
    end else begin
      out_ready <= 1;
    end
  end

  // offer one element item and wait for it to be taken
  task automatic send_item(logic signed [15:0] s, logic signed [15:0] g,
                           logic signed [15:0] h, bit re);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 45 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    sample <= s;
    scale <= g;
    shift <= h;
    row_end <= re;
    do @(posedge clk); while (!in_ready);
    sb.note_input(s, g, h, re);
    items_sent++;
  endtask

  // wait until every expected result has come, then out the compute latency
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [31:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.epsilon = v;
  endtask

  // one row of random content; narrow values now and then so results do not all clip
  task automatic send_row(int len);
    logic signed [15:0] s, g, h;
    for (int k = 0; k < len; k++) begin
      s = 16'($urandom);
      g = 16'($urandom);
      h = 16'($urandom);
      if ($urandom_range(1)) s = 16'(int'($urandom_range(4095)) - 2048);
      if ($urandom_range(1)) g = 16'(int'($urandom_range(1023)) - 512);
      if ($urandom_range(1)) h = 16'(int'($urandom_range(1023)) - 512);
      send_item(s, g, h, k == len - 1);
    end
  endtask

  task automatic random_rows(int budget);
    int goal, len, pick;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 24);
      else len = $urandom_range(60, 68);
      send_row(len);
    end
  endtask

  initial begin
    sb = new();
    idle_mode = IDLE_NONE;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    cycles = 0;
    items_sent = 0;
    rst <= 1;
    in_valid <= 0;
    sample <= 0;
    scale <= 0;
    shift <= 0;
    row_end <= 0;
    out_ready <= 0;
    cfg_valid <= 0;
    cfg_data <= 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, single-element rows, zero variance
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_item(-16'sh8000, -16'sh8000, -16'sh8000, 1);
    send_item(16'sh0100, 16'sh0100, 16'sh0000, 1);
    for (int k = 0; k < 4; k++) send_item(16'sh0200, 16'sh0100, 16'sh0040, k == 3);
    send_item(16'sh7fff, -16'sh8000, 16'sh7fff, 0);
    send_item(16'sh7fff, 16'sh0001, -16'sh8000, 0);
    send_item(-16'sh8000, 16'sh7fff, 16'sh0000, 1);
    // zero epsilon with zero variance takes the largest reciprocal root
    write_epsilon(32'd0);
    send_item(16'sh0123, 16'sh0100, 16'sh0000, 1);
    for (int k = 0; k < 3; k++) send_item(-16'sh0500, 16'sh0001, 16'sh0000, k == 2);
    send_item(16'sh0001, 16'sh0100, 16'sh0000, 0);
    send_item(-16'sh0001, 16'sh0100, 16'sh0000, 1);
    write_epsilon(32'hffff_ffff);
    send_item(16'sh7fff, 16'sh7fff, 16'sh0000, 0);
    send_item(-16'sh8000, 16'sh7fff, 16'sh0000, 1);

    // random phases under each idling pattern
    write_epsilon(32'h0001_0000);
    idle_mode = IDLE_NONE;
    random_rows(16);
    write_epsilon($urandom);
    idle_mode = IDLE_SEND;
    random_rows(16);
    // overlong row, last mark on a dropped element, with a long output hold-off
    write_epsilon($urandom_range(255));
    idle_mode = IDLE_RECV;
    hold_req++;
    send_row(67);
    random_rows(8);
    write_epsilon(32'd1);
    idle_mode = IDLE_BOTH;
    random_rows(16);
    write_epsilon(32'd0);
    idle_mode = IDLE_NONE;
    random_rows(6);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("** layer_norm_row: PASSED **");
    else
      $display("** layer_norm_row: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
